[sv/mbe_pkg.sv]
// Shared types and constants for the escape-time pixel evaluator.
package mbe_pkg;

  localparam int COORD_W     = 32;               // Q-format coordinate width
  localparam int SIDE_W      = 13;               // image side register width
  localparam int PIX_W       = 12;               // column / row width
  localparam int LEVEL_W     = 8;                // level / count width
  localparam int INDEX_W     = 24;               // pixel index width
  localparam int SPAN_W      = COORD_W + 1;      // exact window span
  localparam int DIV_BITS    = SPAN_W;           // quotient bits, one per step
  localparam int DIV_CNT_W   = $clog2(DIV_BITS);
  localparam int CFG_ADDR_W  = 3;
  localparam int IN_TDATA_W  = 2 * PIX_W;
  localparam int OUT_TDATA_W = INDEX_W + LEVEL_W + COORD_W;

  // register indexes of the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_LEFT   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_RIGHT  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_BOTTOM = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW_TOP    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_LEVELS    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLOR_BASE    = 3'd7;

  localparam logic [SIDE_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [SIDE_W-1:0]  RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [LEVEL_W-1:0] RST_MAX_LEVELS   = 8'd64;
  localparam logic [COORD_W-1:0] RST_COLOR_BASE   = 32'd0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP_MUL,
    ST_MAP_SUM,
    ST_ITER_MUL,
    ST_ITER_UPD,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic map_mul;
    logic map_sum;
    logic iter_mul;
    logic iter_upd;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic escaped;
    logic iter_last;
    logic levels_zero;
  } sts_t;

  function automatic logic signed [COORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (COORD_W-1)) - 64'sd1;
    lo = -(64'sd1 <<< (COORD_W-1));
    if (v > hi) begin
      sat32 = hi[COORD_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[COORD_W-1:0];
    end else begin
      sat32 = v[COORD_W-1:0];
    end
  endfunction

endpackage

[sv/mandelbrot_escape_time_pixel.sv]
// Escape-time pixel evaluator: maps (column, row) onto the configured complex
// window and reports the iteration at which z = z*z + c left the radius-2 disk,
// with a packed gray color. One pixel is in flight at a time; it passes through
// a bit-serial division that forms the axis steps, a multiply and a sum state
// for the mapping, and then up to max_levels iterations, each with a state for
// its three 32x32 products and another for the escape test and update. The result
// sits in an output register, so the next pixel is taken while a finished one
// waits on out_tready.
module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS = 26
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mbe_pkg::IN_TDATA_W-1:0]      in_tdata,   // column, row
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mbe_pkg::OUT_TDATA_W-1:0]     out_tdata,  // pixel_index, escape_count, color
  input  logic                                cfg_we,
  input  logic [mbe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mbe_pkg::COORD_W-1:0]         cfg_wdata
);

  localparam int CW = mbe_pkg::COORD_W;
  localparam int PW = mbe_pkg::PIX_W;
  localparam logic signed [CW-1:0] RST_POS_TWO = CW'(2 << FRAC_BITS);

  logic signed [CW-1:0]           left_r, right_r, bottom_r, top_r;
  logic [mbe_pkg::SIDE_W-1:0]     width_r, height_r;
  logic [mbe_pkg::LEVEL_W-1:0]    levels_r;
  logic [CW-1:0]                  base_r;

  logic                           out_valid_r;
  logic [mbe_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                           out_free, idle;
  mbe_pkg::cmd_t                  cmd;
  mbe_pkg::sts_t                  sts;
  logic [mbe_pkg::INDEX_W-1:0]    res_index;
  logic [mbe_pkg::LEVEL_W-1:0]    res_count;
  logic [CW-1:0]                  res_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= -RST_POS_TWO;
      right_r  <= RST_POS_TWO;
      bottom_r <= -RST_POS_TWO;
      top_r    <= RST_POS_TWO;
      width_r  <= mbe_pkg::RST_IMAGE_WIDTH;
      height_r <= mbe_pkg::RST_IMAGE_HEIGHT;
      levels_r <= mbe_pkg::RST_MAX_LEVELS;
      base_r   <= mbe_pkg::RST_COLOR_BASE;
    end else if (cfg_we) begin
      case (cfg_addr)
        mbe_pkg::CFG_WINDOW_LEFT:   left_r   <= cfg_wdata;
        mbe_pkg::CFG_WINDOW_RIGHT:  right_r  <= cfg_wdata;
        mbe_pkg::CFG_WINDOW_BOTTOM: bottom_r <= cfg_wdata;
        mbe_pkg::CFG_WINDOW_TOP:    top_r    <= cfg_wdata;
        mbe_pkg::CFG_IMAGE_WIDTH:   width_r  <= cfg_wdata[mbe_pkg::SIDE_W-1:0];
        mbe_pkg::CFG_IMAGE_HEIGHT:  height_r <= cfg_wdata[mbe_pkg::SIDE_W-1:0];
        mbe_pkg::CFG_MAX_LEVELS:    levels_r <= cfg_wdata[mbe_pkg::LEVEL_W-1:0];
        mbe_pkg::CFG_COLOR_BASE:    base_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = idle;

  mbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .idle     (idle)
  );

  mbe_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .cfg_left   (left_r),
    .cfg_right  (right_r),
    .cfg_bottom (bottom_r),
    .cfg_top    (top_r),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .cfg_levels (levels_r),
    .cfg_base   (base_r),
    .in_column  (in_tdata[PW-1:0]),
    .in_row     (in_tdata[2*PW-1:PW]),
    .res_index  (res_index),
    .res_count  (res_count),
    .res_color  (res_color)
  );

  // output register: holds a finished transaction until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= {res_color, res_count, res_index};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[sv/mbe_ctrl.sv]
// Sequencer for the escape-time evaluator: division, mapping, iteration, output.
module mbe_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          out_free,
  input  mbe_pkg::sts_t sts,
  output mbe_pkg::cmd_t cmd,
  output logic          idle
);

  mbe_pkg::state_t                    state_r, state_nxt;
  logic [mbe_pkg::DIV_CNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic                               div_last;

  assign div_last = (div_cnt_r == mbe_pkg::DIV_CNT_W'(mbe_pkg::DIV_BITS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mbe_pkg::ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = '0;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mbe_pkg::ST_DIV;
      end
      mbe_pkg::ST_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_last) begin
          state_nxt   = mbe_pkg::ST_MAP_MUL;
          div_cnt_nxt = '0;
        end
      end
      mbe_pkg::ST_MAP_MUL: state_nxt = mbe_pkg::ST_MAP_SUM;
      mbe_pkg::ST_MAP_SUM: begin
        state_nxt = sts.levels_zero ? mbe_pkg::ST_DONE : mbe_pkg::ST_ITER_MUL;
      end
      mbe_pkg::ST_ITER_MUL: state_nxt = mbe_pkg::ST_ITER_UPD;
      mbe_pkg::ST_ITER_UPD: begin
        state_nxt = (sts.escaped || sts.iter_last) ? mbe_pkg::ST_DONE
                                                   : mbe_pkg::ST_ITER_MUL;
      end
      mbe_pkg::ST_DONE: begin
        if (out_free) state_nxt = mbe_pkg::ST_IDLE;
      end
      default: state_nxt = mbe_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    idle = 1'b0;
    case (state_r)
      mbe_pkg::ST_IDLE: begin
        idle     = 1'b1;
        cmd.load = in_valid;
      end
      mbe_pkg::ST_DIV:      cmd.div_step = 1'b1;
      mbe_pkg::ST_MAP_MUL:  cmd.map_mul  = 1'b1;
      mbe_pkg::ST_MAP_SUM:  cmd.map_sum  = 1'b1;
      mbe_pkg::ST_ITER_MUL: cmd.iter_mul = 1'b1;
      mbe_pkg::ST_ITER_UPD: cmd.iter_upd = 1'b1;
      mbe_pkg::ST_DONE:     cmd.out_load = out_free;
      default: ;
    endcase
  end

endmodule

[sv/mbe_dpath.sv]
// Datapath: step division, coordinate mapping, z iteration and color.
module mbe_dpath #(
  parameter int FRAC_BITS = 26
) (
  input  logic                                   clk,
  input  mbe_pkg::cmd_t                          cmd,
  output mbe_pkg::sts_t                          sts,
  input  logic signed [mbe_pkg::COORD_W-1:0]     cfg_left,
  input  logic signed [mbe_pkg::COORD_W-1:0]     cfg_right,
  input  logic signed [mbe_pkg::COORD_W-1:0]     cfg_bottom,
  input  logic signed [mbe_pkg::COORD_W-1:0]     cfg_top,
  input  logic [mbe_pkg::SIDE_W-1:0]             cfg_width,
  input  logic [mbe_pkg::SIDE_W-1:0]             cfg_height,
  input  logic [mbe_pkg::LEVEL_W-1:0]            cfg_levels,
  input  logic [mbe_pkg::COORD_W-1:0]            cfg_base,
  input  logic [mbe_pkg::PIX_W-1:0]              in_column,
  input  logic [mbe_pkg::PIX_W-1:0]              in_row,
  output logic [mbe_pkg::INDEX_W-1:0]            res_index,
  output logic [mbe_pkg::LEVEL_W-1:0]            res_count,
  output logic [mbe_pkg::COORD_W-1:0]            res_color
);

  localparam int CW = mbe_pkg::COORD_W;
  localparam int SW = mbe_pkg::SIDE_W;
  localparam int PW = mbe_pkg::PIX_W;
  localparam int LW = mbe_pkg::LEVEL_W;
  localparam int QW = mbe_pkg::DIV_BITS;
  localparam int STEP_W = QW + 1;
  localparam int MPROD_W = PW + 1 + STEP_W;
  localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

  logic [SW-1:0] wd, hd;
  logic signed [mbe_pkg::SPAN_W-1:0] span_x, span_y;
  logic [QW-1:0] mag_x, mag_y;

  logic [PW-1:0]   col_r, row_r;
  logic [QW-1:0]   quo_x_r, quo_y_r;
  logic [SW-1:0]   rem_x_r, rem_y_r;
  logic            neg_x_r, neg_y_r;
  logic [SW:0]     trial_x, trial_y, diff_x, diff_y;
  logic            ge_x, ge_y;

  logic signed [STEP_W-1:0]  step_x, step_y;
  logic signed [MPROD_W-1:0] prod_x_r, prod_y_r;
  logic [PW+SW-1:0]          idx_prod_r;
  logic signed [63:0]        sum_x, sum_y;

  logic signed [CW-1:0] cre_r, cim_r, zr_r, zi_r;
  logic signed [63:0]   rr_r, ii_r, ri_r;
  logic [63:0]          mag_sum;
  logic signed [63:0]   diff_z, nr, ni;
  logic [LW-1:0]        iter_r, count_r;
  logic [mbe_pkg::INDEX_W-1:0] index_r;

  assign wd = (cfg_width  == '0) ? SW'(1) : cfg_width;
  assign hd = (cfg_height == '0) ? SW'(1) : cfg_height;

  assign span_x = {cfg_right[CW-1], cfg_right} - {cfg_left[CW-1], cfg_left};
  assign span_y = {cfg_top[CW-1], cfg_top} - {cfg_bottom[CW-1], cfg_bottom};
  assign mag_x  = span_x[QW-1] ? QW'(-span_x) : QW'(span_x);
  assign mag_y  = span_y[QW-1] ? QW'(-span_y) : QW'(span_y);

  // restoring division, one quotient bit per step; dividend shifts out the top
  assign trial_x = {rem_x_r, quo_x_r[QW-1]};
  assign trial_y = {rem_y_r, quo_y_r[QW-1]};
  assign diff_x  = trial_x - {1'b0, wd};
  assign diff_y  = trial_y - {1'b0, hd};
  assign ge_x    = (trial_x >= {1'b0, wd});
  assign ge_y    = (trial_y >= {1'b0, hd});

  assign step_x = neg_x_r ? -{1'b0, quo_x_r} : {1'b0, quo_x_r};
  assign step_y = neg_y_r ? -{1'b0, quo_y_r} : {1'b0, quo_y_r};

  assign sum_x = 64'(cfg_left) + 64'(prod_x_r);
  assign sum_y = 64'(prod_y_r) - 64'(cfg_top);

  assign mag_sum = $unsigned(rr_r) + $unsigned(ii_r);
  assign diff_z  = rr_r - ii_r;
  assign nr      = (diff_z >>> FRAC_BITS) + 64'(cre_r);
  assign ni      = (ri_r >>> (FRAC_BITS - 1)) + 64'(cim_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_r   <= in_column;
      row_r   <= in_row;
      quo_x_r <= mag_x;
      quo_y_r <= mag_y;
      rem_x_r <= '0;
      rem_y_r <= '0;
      neg_x_r <= span_x[QW-1];
      neg_y_r <= span_y[QW-1];
    end
    if (cmd.div_step) begin
      rem_x_r <= ge_x ? diff_x[SW-1:0] : trial_x[SW-1:0];
      rem_y_r <= ge_y ? diff_y[SW-1:0] : trial_y[SW-1:0];
      quo_x_r <= {quo_x_r[QW-2:0], ge_x};
      quo_y_r <= {quo_y_r[QW-2:0], ge_y};
    end
    if (cmd.map_mul) begin
      prod_x_r   <= $signed({1'b0, col_r}) * step_x;
      prod_y_r   <= $signed({1'b0, row_r}) * step_y;
      idx_prod_r <= row_r * wd;
    end
    if (cmd.map_sum) begin
      cre_r   <= mbe_pkg::sat32(sum_x);
      cim_r   <= mbe_pkg::sat32(sum_y);
      index_r <= mbe_pkg::INDEX_W'(idx_prod_r + (PW+SW)'(col_r));
      zr_r    <= '0;
      zi_r    <= '0;
      iter_r  <= '0;
      count_r <= '0;
    end
    if (cmd.iter_mul) begin
      rr_r <= zr_r * zr_r;
      ii_r <= zi_r * zi_r;
      ri_r <= zr_r * zi_r;
    end
    if (cmd.iter_upd) begin
      if (sts.escaped) begin
        count_r <= iter_r;
      end else begin
        zr_r   <= mbe_pkg::sat32(nr);
        zi_r   <= mbe_pkg::sat32(ni);
        iter_r <= iter_r + 1'b1;
      end
    end
  end

  assign sts.escaped     = (mag_sum > ESC_LIMIT);
  assign sts.iter_last   = (iter_r == cfg_levels - 1'b1);
  assign sts.levels_zero = (cfg_levels == '0);

  assign res_index = index_r;
  assign res_count = count_r;
  assign res_color = (count_r == '0) ? '0 : cfg_base + {count_r, count_r, count_r, 8'h00};

endmodule
